### hdl/tiled_dpcm_decoder_macros.svh
// Assertion macros shared by the decoder's checking code
`ifndef TILED_DPCM_DECODER_MACROS_SVH
`define TILED_DPCM_DECODER_MACROS_SVH

// Check a condition on every clock edge outside reset
`define TDD_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a condition
`define TDD_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/tdd_pkg.sv
// Types and constants shared by the tiled DPCM decoder modules
`timescale 1ns / 1ps
`default_nettype none
package tdd_pkg;

    localparam int TILE_DEF  = 8;
    localparam int SIZE_W    = 4;
    localparam int BW_W      = 4;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 3;
    localparam int BUF_W     = 15;
    localparam int CNT_W     = 4;
    localparam int ACT_W     = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;
    localparam int Q_DEPTH   = 2;

    localparam logic [BW_W-1:0] BW_MAX = 4'd8;

    // Action codes on the input tuser, also used as the command kind
    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BYTE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FRAME = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  kind;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [BW_W-1:0]   bw;
        logic [PIX_W-1:0]  data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

### hdl/tdd_queue.sv
// Two-entry command queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module tdd_queue
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  tdd_pkg::cmd_t     push_cmd,
    input  wire               pop,
    output tdd_pkg::cmd_t     head_cmd,
    output tdd_pkg::q_stat_t  stat
);

    localparam int PTR_W = $clog2(tdd_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(tdd_pkg::Q_DEPTH + 1);

    tdd_pkg::cmd_t     entry_reg [tdd_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == CNT_W'(tdd_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tdd_pkg::Q_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tdd_pkg::Q_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### hdl/tdd_front.sv
// Input side: accepts items, classifies the action and clamps the fields
`timescale 1ns / 1ps
`default_nettype none
module tdd_front
#(
    parameter int TILE = tdd_pkg::TILE_DEF
)
(
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [tdd_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire [tdd_pkg::ACT_W-1:0]       s_tuser,
    input  tdd_pkg::q_stat_t               q_stat,
    output logic                           push,
    output tdd_pkg::cmd_t                  push_cmd
);

    logic [tdd_pkg::SIZE_W-1:0] raw_w;
    logic [tdd_pkg::SIZE_W-1:0] raw_h;
    logic [tdd_pkg::BW_W-1:0]   raw_bw;
    logic [tdd_pkg::PIX_W-1:0]  raw_seed;
    logic [tdd_pkg::PIX_W-1:0]  raw_byte;

    assign raw_w    = s_tdata[3:0];
    assign raw_h    = s_tdata[7:4];
    assign raw_bw   = s_tdata[11:8];
    assign raw_seed = s_tdata[19:12];
    assign raw_byte = s_tdata[27:20];

    assign s_tready = !q_stat.full;

    // Drop the unused action code: the transfer completes but queues nothing
    assign push = s_tvalid && s_tready &&
                  (s_tuser == tdd_pkg::ACT_START || s_tuser == tdd_pkg::ACT_BYTE ||
                   s_tuser == tdd_pkg::ACT_FRAME);

    always_comb
    begin
        push_cmd.kind = s_tuser;
        push_cmd.w    = (raw_w == '0) ? tdd_pkg::SIZE_W'(1) : raw_w;
        if (32'(push_cmd.w) > TILE)
        begin
            push_cmd.w = tdd_pkg::SIZE_W'(TILE);
        end
        push_cmd.h    = (raw_h == '0) ? tdd_pkg::SIZE_W'(1) : raw_h;
        if (32'(push_cmd.h) > TILE)
        begin
            push_cmd.h = tdd_pkg::SIZE_W'(TILE);
        end
        push_cmd.bw   = (raw_bw > tdd_pkg::BW_MAX) ? tdd_pkg::BW_MAX : raw_bw;
        push_cmd.data = (s_tuser == tdd_pkg::ACT_START) ? raw_seed : raw_byte;
    end

endmodule
`default_nettype wire

### hdl/tdd_back.sv
// Execution side: bit buffer, residual decode, pixel walk and output register
`timescale 1ns / 1ps
`default_nettype none
module tdd_back
#(
    parameter int TILE = tdd_pkg::TILE_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  tdd_pkg::cmd_t                  cmd,
    input  wire                            cmd_valid,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [tdd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int CW = $clog2(TILE);
    localparam int SW = tdd_pkg::SIZE_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLAT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                   state_reg,  state_next;
    logic [tdd_pkg::BUF_W-1:0]    buf_reg,    buf_next;
    logic [tdd_pkg::CNT_W-1:0]    cnt_reg,    cnt_next;
    logic                         active_reg, active_next;
    logic [CW-1:0]                x_reg,      x_next;
    logic [CW-1:0]                y_reg,      y_next;
    logic [tdd_pkg::PIX_W-1:0]    left_reg,   left_next;
    logic [tdd_pkg::PIX_W-1:0]    row_reg,    row_next;
    logic [tdd_pkg::SIZE_W-1:0]   w_reg,      w_next;
    logic [tdd_pkg::SIZE_W-1:0]   h_reg,      h_next;
    logic [tdd_pkg::BW_W-1:0]     wiu_reg,    wiu_next;

    logic                         ovalid_reg, ovalid_next;
    logic [tdd_pkg::PIX_W-1:0]    opix_reg,   opix_next;
    logic [tdd_pkg::POS_W-1:0]    ox_reg,     ox_next;
    logic [tdd_pkg::POS_W-1:0]    oy_reg,     oy_next;
    logic                         olast_reg,  olast_next;
    logic                         oerr_reg,   oerr_next;

    logic                         out_free;
    logic                         emit_px;
    logic                         emit_err;
    logic                         use_new;
    logic [tdd_pkg::PIX_W-1:0]    px;
    logic [tdd_pkg::SIZE_W-1:0]   e_w;
    logic [tdd_pkg::SIZE_W-1:0]   e_h;
    logic [CW-1:0]                e_x;
    logic [CW-1:0]                e_y;
    logic                         x_end;
    logic                         e_last;
    logic                         can_drain;
    logic [tdd_pkg::BUF_W-1:0]    mask;
    logic [tdd_pkg::PIX_W-1:0]    z;
    logic [tdd_pkg::PIX_W-1:0]    d;
    logic [tdd_pkg::PIX_W-1:0]    pred;

    assign out_free  = !ovalid_reg || m_tready;
    assign can_drain = active_reg && (wiu_reg != '0) &&
                       (cnt_reg >= tdd_pkg::CNT_W'(wiu_reg));

    // Residual extraction and zigzag undo
    assign mask = (tdd_pkg::BUF_W'(1) << wiu_reg) - tdd_pkg::BUF_W'(1);
    assign z    = tdd_pkg::PIX_W'(buf_reg & mask);
    assign d    = {1'b0, z[tdd_pkg::PIX_W-1:1]} ^ {tdd_pkg::PIX_W{z[0]}};
    assign pred = (x_reg == '0) ? row_reg : left_reg;

    always_comb
    begin
        state_next  = state_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        left_next   = left_reg;
        row_next    = row_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        wiu_next    = wiu_reg;
        ovalid_next = ovalid_reg;
        opix_next   = opix_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        cmd_pop     = 1'b0;
        emit_px     = 1'b0;
        emit_err    = 1'b0;
        use_new     = 1'b0;
        px          = left_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        tdd_pkg::ACT_START:
                        begin
                            if (active_reg)
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                w_next      = cmd.w;
                                h_next      = cmd.h;
                                wiu_next    = cmd.bw;
                                active_next = 1'b1;
                                use_new     = 1'b1;
                                emit_px     = 1'b1;
                                px          = cmd.data;
                                state_next  = (cmd.bw == '0) ? ST_FLAT : ST_DRAIN;
                            end
                        end
                        tdd_pkg::ACT_BYTE:
                        begin
                            if (cnt_reg > tdd_pkg::CNT_W'(tdd_pkg::BUF_W - tdd_pkg::PIX_W))
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                buf_next   = buf_reg |
                                             (tdd_pkg::BUF_W'(cmd.data) << cnt_reg);
                                cnt_next   = cnt_reg + tdd_pkg::CNT_W'(tdd_pkg::PIX_W);
                                state_next = ST_DRAIN;
                            end
                        end
                        tdd_pkg::ACT_FRAME:
                        begin
                            buf_next = '0;
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FLAT:
            begin
                // Repeat the seed, held in left_reg, until the tile ends
                if (!active_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit_px = 1'b1;
                    px      = left_reg;
                end
            end
            ST_DRAIN:
            begin
                if (!can_drain)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit_px  = 1'b1;
                    px       = pred + d;
                    buf_next = buf_reg >> wiu_reg;
                    cnt_next = cnt_reg - tdd_pkg::CNT_W'(wiu_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Pixel walk, using the new tile size for the seed pixel
        e_w    = use_new ? cmd.w : w_reg;
        e_h    = use_new ? cmd.h : h_reg;
        e_x    = use_new ? '0 : x_reg;
        e_y    = use_new ? '0 : y_reg;
        x_end  = (SW'(e_x) + SW'(1)) >= SW'(e_w);
        e_last = x_end && ((SW'(e_y) + SW'(1)) >= SW'(e_h));

        if (emit_px)
        begin
            ovalid_next = 1'b1;
            opix_next   = px;
            ox_next     = tdd_pkg::POS_W'(e_x);
            oy_next     = tdd_pkg::POS_W'(e_y);
            olast_next  = e_last;
            oerr_next   = 1'b0;
            left_next   = px;
            if (e_x == '0)
            begin
                row_next = px;
            end
            if (e_last)
            begin
                active_next = 1'b0;
                x_next      = '0;
                y_next      = '0;
            end
            else if (x_end)
            begin
                x_next = '0;
                y_next = e_y + CW'(1);
            end
            else
            begin
                x_next = e_x + CW'(1);
                y_next = e_y;
            end
        end
        else if (emit_err)
        begin
            ovalid_next = 1'b1;
            opix_next   = '0;
            ox_next     = '0;
            oy_next     = '0;
            olast_next  = 1'b0;
            oerr_next   = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            buf_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            left_reg   <= '0;
            row_reg    <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            wiu_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            left_reg   <= left_next;
            row_reg    <= row_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            wiu_reg    <= wiu_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opix_reg  <= opix_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, oy_reg, ox_reg, opix_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

endmodule
`default_nettype wire

### hdl/tiled_dpcm_decoder.sv
// Tiled DPCM decoder, top level
// Input stream s_*: tuser carries the action (start tile-channel, payload
// byte, frame start); tdata carries sizes, bit width, seed and payload.
// Output stream m_*: one transfer per pixel, tlast on the final pixel of a
// tile-channel, tuser set on a rejected item (overflow or start while busy).
// Items pass through a two-entry command queue; input is taken whenever the
// queue has room, so the sender only stalls when the decoder falls behind.
// With the queue empty, the first result of a start passes through the queue
// entry and the output register; that of a payload byte also passes through
// the bit buffer update before the drain state. The engine takes a command
// from the queue in its idle state. A payload byte then yields one pixel per
// cycle while the receiver is ready, for each residual it completes (up to
// eight with one-bit residuals), and returns to idle; a start does the same
// with the residuals already waiting, or repeats the seed for each pixel of
// the tile when the bit width is zero. A frame start or a rejected item is
// handled in the idle state. The pixel walk and the single output register
// set this rate.
// While the receiver stalls, the engine holds its result and waits; the
// queue still takes items until it holds two. Reset empties the queue and
// the bit buffer and leaves the decoder idle with no tile-channel open.
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_dpcm_decoder_macros.svh"
module tiled_dpcm_decoder
#(
    parameter int TILE = tdd_pkg::TILE_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // tile_w[3:0], tile_h[7:4], bit_width[11:8], seed[19:12], payload_byte[27:20]
    input  wire [tdd_pkg::S_DATA_W-1:0]    s_tdata,
    // action[1:0]
    input  wire [tdd_pkg::ACT_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // pixel[7:0], pos_x[10:8], pos_y[13:11]
    output logic [tdd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    // error[0]
    output logic                           m_tuser
);

    tdd_pkg::q_stat_t q_stat;
    tdd_pkg::cmd_t    push_cmd;
    tdd_pkg::cmd_t    head_cmd;
    logic             push;
    logic             pop;

    tdd_front #(
        .TILE (TILE)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tdd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    tdd_back #(
        .TILE (TILE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!q_stat.empty),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `TDD_ASSERT(a_err_no_last, !(m_tvalid && m_tuser && m_tlast), "error result marked last")
    `TDD_ASSERT(a_err_zero, !(m_tvalid && m_tuser) || (m_tdata == '0), "error result not zero")
    `TDD_ASSERT(a_q_stat, !(q_stat.full && q_stat.empty), "queue both full and empty")
    `TDD_ASSERT_NEXT(a_pop_loads, pop, m_tvalid || q_stat.empty || !q_stat.full, "pop lost")

endmodule
`default_nettype wire
